### src/badrc_pkg.sv
// ----------------------------------------------------------------------------
// badrc_pkg
// Shared types and constants for the dirty-range coalescer.
// ----------------------------------------------------------------------------
`default_nettype none
package badrc_pkg;

  // Field widths fixed by the item format
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned CNT17_W = 17;
  localparam int unsigned IDX16_W = 16;
  localparam int unsigned END_W   = 18;
  // Largest range store supported (64 entries)
  localparam int unsigned SLOT_W  = 6;
  localparam int unsigned NUM_W   = 7;

  typedef enum logic [1:0] {
    CMD_ALLOC = 2'd0,
    CMD_MARK  = 2'd1,
    CMD_FLUSH = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_ROOM = 2'd1,
    ST_BAD_IDX = 2'd2,
    ST_EMPTY   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    OP_REPLY,
    OP_FLUSH_ALL,
    OP_FLUSH_EMPTY,
    OP_FLUSH_SORT
  } op_kind_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SCAN,
    BK_DRAIN,
    BK_MERGE,
    BK_FINAL
  } bk_state_e;

  // Config register index
  localparam logic REG_CAPACITY = 1'b0;

  // Work item passed from front to back
  typedef struct packed {
    op_kind_e               kind;
    status_e                status;
    logic [IDX16_W-1:0]     base;
    logic                   wr;      // record a range
    logic [SLOT_W-1:0]      slot;
    logic [CNT17_W-1:0]     rstart;
    logic [CNT17_W-1:0]     rlen;
    logic [NUM_W-1:0]       num;     // ranges to sort
    logic [CNT17_W-1:0]     fill;    // fill count for the overflow flush
  } op_t;

  // One result beat
  typedef struct packed {
    status_e                status;
    logic [IDX16_W-1:0]     base;
    logic [IDX16_W-1:0]     offset;
    logic [CNT17_W-1:0]     count;
    logic                   last;
  } res_t;

endpackage
`default_nettype wire

### src/badrc_if.sv
// ----------------------------------------------------------------------------
// badrc_if
// Valid/ready channels for command beats and result beats.
// ----------------------------------------------------------------------------
`default_nettype none
interface badrc_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [16:0] block_count;
  logic [15:0] entry_index;
  modport source (output valid, command, block_count, entry_index, input ready);
  modport sink   (input valid, command, block_count, entry_index, output ready);
endinterface

interface badrc_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] base_index;
  logic [15:0] range_offset;
  logic [16:0] range_count;
  logic        last;
  modport source (output valid, status, base_index, range_offset, range_count, last,
                  input ready);
  modport sink   (input valid, status, base_index, range_offset, range_count, last,
                  output ready);
endinterface
`default_nettype wire

### src/badrc_ram.sv
// ----------------------------------------------------------------------------
// badrc_ram
// Generic one-write, one-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module badrc_ram #(
  parameter int unsigned WIDTH = 34,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

### src/badrc_fifo.sv
// ----------------------------------------------------------------------------
// badrc_fifo
// Short queue of work items between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none
module badrc_fifo
  import badrc_pkg::*;
#(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire op_t  data_i,
  output      logic full_o,
  input  wire logic pop_i,
  output      logic empty_o,
  output      op_t  data_o
);
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  op_t              mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];

  // pointer and count update
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end
endmodule
`default_nettype wire

### src/badrc_front.sv
// ----------------------------------------------------------------------------
// badrc_front
// Accepts commands, keeps the fill count and range bookkeeping, and turns
// each command into a work item for the back end. Holds the config port.
// ----------------------------------------------------------------------------
`default_nettype none
module badrc_front
  import badrc_pkg::*;
#(
  parameter int unsigned HEAP_ENTRIES = 65536,
  parameter int unsigned MAX_RANGES   = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  badrc_cmd_if.sink        in_ch,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output      logic [31:0] prdata,
  output      logic        pready,
  output      logic        push_o,
  output      op_t         op_o,
  input  wire logic        full_i
);
  localparam int unsigned HELD_W = $clog2(MAX_RANGES + 1);

  logic [CNT17_W-1:0] capacity_q;
  logic [CNT17_W-1:0] fill_q, fill_d;
  logic [HELD_W-1:0]  held_q, held_d;
  logic               ovf_q, ovf_d;
  logic [CNT17_W-1:0] cap_eff;
  logic [END_W-1:0]   alloc_end;
  logic               accept;
  logic               store_full;

  // config port
  assign pready = 1'b1;
  assign prdata = {15'd0, capacity_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= 17'd65536;
    end else if (psel && penable && pwrite && paddr[2] == REG_CAPACITY) begin
      capacity_q <= pwdata[CNT17_W-1:0];
    end
  end

  assign in_ch.ready = !full_i;
  assign accept      = in_ch.valid && !full_i;
  assign cap_eff     = ({4'd0, capacity_q} > 21'(HEAP_ENTRIES)) ?
                       CNT17_W'(HEAP_ENTRIES) : capacity_q;
  assign alloc_end   = {1'b0, fill_q} + {1'b0, in_ch.block_count};
  assign store_full  = (held_q >= HELD_W'(MAX_RANGES));

  // classify the command
  always_comb begin
    op_o        = '0;
    op_o.kind   = OP_REPLY;
    op_o.status = ST_OK;
    op_o.fill   = fill_q;
    op_o.num    = NUM_W'(held_q);
    op_o.slot   = SLOT_W'(held_q);
    push_o      = 1'b0;
    fill_d      = fill_q;
    held_d      = held_q;
    ovf_d       = ovf_q;
    if (accept) begin
      case (in_ch.command)
        CMD_ALLOC: begin
          push_o = 1'b1;
          if (in_ch.block_count == '0) begin
            op_o.status = ST_OK;
          end else if (alloc_end > {1'b0, cap_eff}) begin
            op_o.status = ST_NO_ROOM;
          end else begin
            op_o.base   = fill_q[IDX16_W-1:0];
            op_o.rstart = fill_q;
            op_o.rlen   = in_ch.block_count;
            fill_d      = alloc_end[CNT17_W-1:0];
            if (store_full) begin
              ovf_d = 1'b1;
            end else begin
              op_o.wr = 1'b1;
              held_d  = held_q + HELD_W'(1);
            end
          end
        end
        CMD_MARK: begin
          push_o = 1'b1;
          if ({1'b0, in_ch.entry_index} >= fill_q) begin
            op_o.status = ST_BAD_IDX;
          end else begin
            op_o.rstart = {1'b0, in_ch.entry_index};
            op_o.rlen   = CNT17_W'(1);
            if (store_full) begin
              ovf_d = 1'b1;
            end else begin
              op_o.wr = 1'b1;
              held_d  = held_q + HELD_W'(1);
            end
          end
        end
        CMD_FLUSH: begin
          push_o = 1'b1;
          if (ovf_q) begin
            op_o.kind = OP_FLUSH_ALL;
            ovf_d     = 1'b0;
            held_d    = '0;
          end else if (held_q == '0) begin
            op_o.kind   = OP_FLUSH_EMPTY;
            op_o.status = ST_EMPTY;
          end else begin
            op_o.kind = OP_FLUSH_SORT;
            held_d    = '0;
          end
        end
        default: begin
          push_o = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      held_q <= '0;
      ovf_q  <= 1'b0;
    end else begin
      fill_q <= fill_d;
      held_q <= held_d;
      ovf_q  <= ovf_d;
    end
  end
endmodule
`default_nettype wire

### src/badrc_back.sv
// ----------------------------------------------------------------------------
// badrc_back
// Executes work items: records ranges in the range RAM, answers commands,
// and on a sorting flush repeatedly scans the RAM for the lowest unconsumed start,
// merging it into the current range and emitting finished ranges.
// ----------------------------------------------------------------------------
`default_nettype none
module badrc_back
  import badrc_pkg::*;
#(
  parameter int unsigned MAX_RANGES = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic empty_i,
  input  wire op_t  op_i,
  output      logic pop_o,
  badrc_res_if.source out_ch
);
  localparam int unsigned IDX_W = $clog2(MAX_RANGES);
  localparam int unsigned RAM_W = 2 * CNT17_W;

  bk_state_e st_q, st_d;

  logic                  out_valid_q;
  res_t                  out_q;
  logic                  out_free;
  logic                  out_load;
  res_t                  out_d;

  logic [MAX_RANGES-1:0] used_q;
  logic [IDX_W-1:0]      addr_q;
  logic [IDX_W-1:0]      rd_idx_q;
  logic                  rd_valid_q;
  logic [NUM_W-1:0]      num_q;
  logic [NUM_W-1:0]      rounds_q;
  logic                  best_found_q;
  logic [CNT17_W-1:0]    best_s_q;
  logic [CNT17_W-1:0]    best_l_q;
  logic [IDX_W-1:0]      best_i_q;
  logic                  have_cur_q;
  logic [END_W-1:0]      cur_off_q;
  logic [END_W-1:0]      cur_end_q;

  logic [RAM_W-1:0]      rdata;
  logic [CNT17_W-1:0]    rd_s;
  logic [CNT17_W-1:0]    rd_l;
  logic [END_W-1:0]      best_end;
  logic                  last_addr;
  logic                  take_rd;
  logic                  gap;
  logic                  merge_go;
  logic [END_W-1:0]      cur_cnt;

  badrc_ram #(
    .WIDTH (RAM_W),
    .DEPTH (MAX_RANGES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (st_q == BK_IDLE && !empty_i && op_i.kind == OP_REPLY && op_i.wr && out_free),
    .waddr_i (IDX_W'(op_i.slot)),
    .wdata_i ({op_i.rstart, op_i.rlen}),
    .raddr_i (addr_q),
    .rdata_o (rdata)
  );

  assign rd_s      = rdata[RAM_W-1:CNT17_W];
  assign rd_l      = rdata[CNT17_W-1:0];
  assign best_end  = {1'b0, best_s_q} + {1'b0, best_l_q};
  assign last_addr = (NUM_W'(addr_q) == num_q - NUM_W'(1));
  assign take_rd   = rd_valid_q && !used_q[rd_idx_q] &&
                     (!best_found_q || rd_s < best_s_q);
  assign gap       = have_cur_q && (cur_end_q < {1'b0, best_s_q});
  assign merge_go  = !gap || out_free;
  assign cur_cnt   = cur_end_q - cur_off_q;
  assign out_free  = !out_valid_q || out_ch.ready;

  // next state
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      BK_IDLE: begin
        if (!empty_i && op_i.kind == OP_FLUSH_SORT) begin
          st_d = BK_SCAN;
        end
      end
      BK_SCAN: begin
        if (last_addr) begin
          st_d = BK_DRAIN;
        end
      end
      BK_DRAIN: st_d = BK_MERGE;
      BK_MERGE: begin
        if (merge_go) begin
          st_d = (rounds_q == NUM_W'(1)) ? BK_FINAL : BK_SCAN;
        end
      end
      BK_FINAL: begin
        if (out_free) begin
          st_d = BK_IDLE;
        end
      end
      default: st_d = BK_IDLE;
    endcase
  end

  // result and queue control
  always_comb begin
    out_load = 1'b0;
    out_d    = '0;
    out_d.last = 1'b1;
    pop_o    = 1'b0;
    unique case (st_q)
      BK_IDLE: begin
        if (!empty_i && op_i.kind != OP_FLUSH_SORT && out_free) begin
          out_load     = 1'b1;
          pop_o        = 1'b1;
          out_d.status = op_i.status;
          if (op_i.kind == OP_REPLY) begin
            out_d.base = op_i.base;
          end
          if (op_i.kind == OP_FLUSH_ALL) begin
            out_d.count = op_i.fill;
          end
        end
      end
      BK_MERGE: begin
        if (gap && out_free) begin
          out_load     = 1'b1;
          out_d.offset = cur_off_q[IDX16_W-1:0];
          out_d.count  = cur_cnt[CNT17_W-1:0];
          out_d.last   = 1'b0;
        end
      end
      BK_FINAL: begin
        if (out_free) begin
          out_load     = 1'b1;
          pop_o        = 1'b1;
          out_d.offset = cur_off_q[IDX16_W-1:0];
          out_d.count  = cur_cnt[CNT17_W-1:0];
        end
      end
      default: begin
        out_load = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= BK_IDLE;
      out_valid_q <= 1'b0;
      rd_valid_q  <= 1'b0;
    end else begin
      st_q        <= st_d;
      rd_valid_q  <= (st_q == BK_SCAN);
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // sort and merge datapath
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= out_d;
    end
    rd_idx_q <= addr_q;
    if (take_rd) begin
      best_found_q <= 1'b1;
      best_s_q     <= rd_s;
      best_l_q     <= rd_l;
      best_i_q     <= rd_idx_q;
    end
    case (st_q)
      BK_IDLE: begin
        used_q     <= '0;
        have_cur_q <= 1'b0;
        addr_q     <= '0;
        num_q      <= op_i.num;
        rounds_q   <= op_i.num;
        best_found_q <= 1'b0;
      end
      BK_SCAN: begin
        addr_q <= addr_q + IDX_W'(1);
      end
      BK_MERGE: begin
        if (merge_go) begin
          used_q[best_i_q] <= 1'b1;
          rounds_q         <= rounds_q - NUM_W'(1);
          addr_q           <= '0;
          best_found_q     <= 1'b0;
          have_cur_q       <= 1'b1;
          if (!have_cur_q || gap) begin
            cur_off_q <= {1'b0, best_s_q};
            cur_end_q <= best_end;
          end else if (best_end > cur_end_q) begin
            cur_end_q <= best_end;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign out_ch.valid        = out_valid_q;
  assign out_ch.status       = out_q.status;
  assign out_ch.base_index   = out_q.base;
  assign out_ch.range_offset = out_q.offset;
  assign out_ch.range_count  = out_q.count;
  assign out_ch.last         = out_q.last;

  // scans only run over held ranges
  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == BK_SCAN |-> (NUM_W'(addr_q) < num_q && rounds_q != '0))
    else $error("scan beyond held ranges");

  // an intermediate range only leaves while merging
  a_mid_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && !out_d.last) |-> st_q == BK_MERGE)
    else $error("non-final beat outside merge");

  // the queue is only popped when it holds an item
  a_pop_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> !empty_i)
    else $error("pop from empty queue");

  // a merge step always follows a completed scan
  a_merge_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == BK_MERGE && $past(st_q) != BK_MERGE) |-> $past(st_q) == BK_DRAIN)
    else $error("merge entered without scan");
endmodule
`default_nettype wire

### src/bump_allocator_dirty_range_coalescer.sv
// ----------------------------------------------------------------------------
// bump_allocator_dirty_range_coalescer
// Bump allocator over a heap with dirty-range tracking and merged flush.
// ----------------------------------------------------------------------------
// Channels: in_ch carries command beats (allocate, mark, flush), out_ch
// carries result beats; both are valid/ready. The capacity register is
// written at APB addresses 0 to 3 and reads back at every address.
// Allocate and mark give one result beat; a command is taken whenever the
// queue is not full, and its result is registered through the queue and the
// result register, one beat per cycle sustained while out_ch is ready and no
// sorting flush runs. A flush of N held ranges scans the range RAM once per
// range, one entry at a time through the single RAM read port, waits on result
// stalls, and gives one beat per merged range, last on the final.
// Overflow and empty flushes give a single beat.
// A two-deep queue parts the command side from the result side; the front
// keeps taking commands while results wait, until the queue fills.
// Reset clears the fill count, range count, overflow flag and sets capacity
// to 65536. Range RAM contents are not cleared. A stalled result holds.
// ----------------------------------------------------------------------------
`default_nettype none
module bump_allocator_dirty_range_coalescer
  import badrc_pkg::*;
#(
  parameter int unsigned HEAP_ENTRIES = 65536,
  parameter int unsigned MAX_RANGES   = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  badrc_cmd_if.sink        in_ch,
  badrc_res_if.source      out_ch,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output      logic [31:0] prdata,
  output      logic        pready
);
  logic push, pop, full, empty;
  op_t  op_in, op_out;

  badrc_front #(
    .HEAP_ENTRIES (HEAP_ENTRIES),
    .MAX_RANGES   (MAX_RANGES)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_ch   (in_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .push_o  (push),
    .op_o    (op_in),
    .full_i  (full)
  );

  badrc_fifo #(
    .DEPTH (2)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (op_in),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (op_out)
  );

  badrc_back #(
    .MAX_RANGES (MAX_RANGES)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .op_i    (op_out),
    .pop_o   (pop),
    .out_ch  (out_ch)
  );
endmodule
`default_nettype wire

### test/badrc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// badrc_checker
// Watches the command and result channels of the dirty-range coalescer,
// predicts every result beat from accepted commands and compares them.
// ----------------------------------------------------------------------------
`default_nettype none
module badrc_checker
  import badrc_pkg::*;
#(
  parameter int unsigned HEAP_ENTRIES = 65536,
  parameter int unsigned MAX_RANGES   = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cmd_valid_i,
  input  wire logic        cmd_ready_i,
  input  wire logic [1:0]  cmd_i,
  input  wire logic [16:0] count_i,
  input  wire logic [15:0] index_i,
  input  wire logic        res_valid_i,
  input  wire logic        res_ready_i,
  input  wire logic [1:0]  status_i,
  input  wire logic [15:0] base_i,
  input  wire logic [15:0] offset_i,
  input  wire logic [16:0] rcount_i,
  input  wire logic        last_i,
  input  wire logic        cap_we_i,
  input  wire logic [16:0] cap_val_i,
  output int               errors_o,
  output int               pending_o
);

  res_t        beats_due[$];
  logic [16:0] cap_q;
  logic [16:0] fill_q;
  logic [15:0] starts_q[MAX_RANGES];
  logic [16:0] lens_q[MAX_RANGES];
  int          held_q;
  bit          ovf_q;
  int          errs = 0;

  assign pending_o = beats_due.size();
  assign errors_o  = errs;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    errs++;
  endtask

  function automatic res_t mk(status_e st, logic [15:0] b, logic [15:0] o,
                              logic [16:0] c, logic l);
    res_t r;
    r.status = st; r.base = b; r.offset = o; r.count = c; r.last = l;
    return r;
  endfunction

  // append one predicted beat
  task automatic queue_beat(input res_t r);
    beats_due.insert(beats_due.size(), r);
  endtask

  task automatic note_range(input logic [15:0] s, input logic [16:0] l);
    if (held_q >= MAX_RANGES) ovf_q = 1;
    else begin
      starts_q[held_q] = s; lens_q[held_q] = l; held_q++;
    end
  endtask

  // predict the beats of one command
  task automatic predict_cmd(input logic [1:0] c, input logic [16:0] n, input logic [15:0] ix);
    logic [17:0] cap, e, cur_off, cur_end;
    logic [15:0] s;
    logic [16:0] l;
    int j;
    cap = (cap_q > HEAP_ENTRIES) ? HEAP_ENTRIES : cap_q;
    case (c)
      CMD_ALLOC: begin
        if (n == 0) queue_beat(mk(ST_OK, 0, 0, 0, 1));
        else if ({1'b0, fill_q} + n > cap) queue_beat(mk(ST_NO_ROOM, 0, 0, 0, 1));
        else begin
          note_range(fill_q[15:0], n);
          queue_beat(mk(ST_OK, fill_q[15:0], 0, 0, 1));
          fill_q = fill_q + n;
        end
      end
      CMD_MARK: begin
        if ({1'b0, ix} >= fill_q) queue_beat(mk(ST_BAD_IDX, 0, 0, 0, 1));
        else begin
          note_range(ix, 1);
          queue_beat(mk(ST_OK, 0, 0, 0, 1));
        end
      end
      CMD_FLUSH: begin
        if (ovf_q) begin
          queue_beat(mk(ST_OK, 0, 0, fill_q, 1));
          ovf_q = 0; held_q = 0;
        end else if (held_q == 0) queue_beat(mk(ST_EMPTY, 0, 0, 0, 1));
        else begin
          // stable insertion sort by start
          for (int i = 1; i < held_q; i++) begin
            s = starts_q[i]; l = lens_q[i]; j = i;
            while (j > 0 && starts_q[j-1] > s) begin
              starts_q[j] = starts_q[j-1]; lens_q[j] = lens_q[j-1]; j--;
            end
            starts_q[j] = s; lens_q[j] = l;
          end
          cur_off = starts_q[0];
          cur_end = starts_q[0] + lens_q[0];
          for (int i = 1; i < held_q; i++) begin
            e = starts_q[i] + lens_q[i];
            if (cur_end >= starts_q[i]) begin
              if (e > cur_end) cur_end = e;
            end else begin
              queue_beat(mk(ST_OK, 0, cur_off[15:0], 17'(cur_end - cur_off), 0));
              cur_off = starts_q[i]; cur_end = e;
            end
          end
          queue_beat(mk(ST_OK, 0, cur_off[15:0], 17'(cur_end - cur_off), 1));
          held_q = 0;
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    if (!rst_ni) begin
      cap_q = 17'd65536; fill_q = 0; held_q = 0; ovf_q = 0;
      beats_due.delete();
    end else begin
      if (res_valid_i && res_ready_i) begin
        if (beats_due.size() == 0) report("unexpected beat", status_i, 0);
        else begin
          want = beats_due.pop_front();
          if (status_i !== want.status) report("status", status_i, want.status);
          if (base_i !== want.base) report("base_index", base_i, want.base);
          if (offset_i !== want.offset) report("range_offset", offset_i, want.offset);
          if (rcount_i !== want.count) report("range_count", rcount_i, want.count);
          if (last_i !== want.last) report("last", last_i, want.last);
        end
      end
      if (cmd_valid_i && cmd_ready_i) predict_cmd(cmd_i, count_i, index_i);
      if (cap_we_i) cap_q = cap_val_i;
    end
  end

endmodule
`default_nettype wire

### test/bump_allocator_dirty_range_coalescer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bump_allocator_dirty_range_coalescer_tb
// Drives directed and random allocate/mark/flush beats under random stalls,
// rewrites capacity between phases and leaves checking to badrc_checker.
// ----------------------------------------------------------------------------
`default_nettype none
module bump_allocator_dirty_range_coalescer_tb;
  import badrc_pkg::*;

  localparam int WATCH_LIMIT = 20000;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        psel = 0, penable = 0, pwrite = 0;
  logic [2:0]  paddr = 0;
  logic [31:0] pwdata = 0;
  logic [31:0] prdata;
  logic        pready;
  int          errors, pending;
  int          idle_cycles = 0;
  bit          no_stall;
  bit          sink_hold;

  badrc_cmd_if in_ch();
  badrc_res_if out_ch();

  always #5 clk_i = ~clk_i;

  bump_allocator_dirty_range_coalescer dut (
    .clk_i, .rst_ni, .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  badrc_checker chk (
    .clk_i, .rst_ni,
    .cmd_valid_i(in_ch.valid), .cmd_ready_i(in_ch.ready), .cmd_i(in_ch.command),
    .count_i(in_ch.block_count), .index_i(in_ch.entry_index),
    .res_valid_i(out_ch.valid), .res_ready_i(out_ch.ready), .status_i(out_ch.status),
    .base_i(out_ch.base_index), .offset_i(out_ch.range_offset),
    .rcount_i(out_ch.range_count), .last_i(out_ch.last),
    .cap_we_i(psel && penable && pwrite && pready && paddr == 3'd0),
    .cap_val_i(pwdata[16:0]),
    .errors_o(errors), .pending_o(pending)
  );

  initial begin
    in_ch.valid = 0; in_ch.command = 0; in_ch.block_count = 0; in_ch.entry_index = 0;
    out_ch.ready = 0;
  end

  // result side: ready with random stall bursts
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      n = $urandom_range(1, 16);
      sink_hold = !no_stall && ($urandom_range(0, 2) == 0);
      repeat (n) begin
        @(posedge clk_i);
        out_ch.ready <= !sink_hold;
      end
    end
  end

  // watchdog on cycles without any accepted beat or config access
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCH_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic send(input cmd_e c, input logic [16:0] n, input logic [15:0] ix);
    if (!no_stall && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    in_ch.valid <= 1; in_ch.command <= c; in_ch.block_count <= n; in_ch.entry_index <= ix;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  task automatic drain;
    in_ch.valid <= 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_capacity(input logic [16:0] v);
    drain();
    psel <= 1; pwrite <= 1; paddr <= 3'd0; pwdata <= {15'd0, v};
    @(posedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    psel <= 0; penable <= 0; pwrite <= 0;
    @(posedge clk_i);
  endtask

  // random allocs use small counts mostly, sometimes any 17-bit value
  function automatic logic [16:0] rnd_count();
    case ($urandom_range(0, 9))
      0: return 17'($urandom_range(0, 131071));
      1: return 0;
      default: return 17'($urandom_range(1, 40));
    endcase
  endfunction

  initial begin
    logic [16:0] caps[5];
    caps = '{17'd0, 17'd65536, 17'd131071, 17'd300, 17'd65535};
    no_stall = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: empty flush, zero count, overflow, touching ranges, bad mark
    send(CMD_FLUSH, 0, 0);
    send(CMD_ALLOC, 0, 0);
    send(CMD_MARK, 0, 0);
    send(CMD_ALLOC, 17'd65537, 0);
    send(CMD_ALLOC, 10, 0);
    send(CMD_ALLOC, 5, 0);
    send(CMD_MARK, 3, 16'hFFFF);
    send(CMD_MARK, 0, 14);
    send(CMD_MARK, 0, 15);
    send(CMD_MARK, 0, 13);
    send(CMD_NONE, 17'h1FFFF, 16'hFFFF);
    send(CMD_FLUSH, 0, 0);
    for (int i = 0; i < 17; i++) send(CMD_MARK, 0, 16'(i % 15));
    send(CMD_FLUSH, 0, 0);
    send(CMD_ALLOC, 17'd65521, 0);
    send(CMD_ALLOC, 1, 0);
    send(CMD_MARK, 0, 16'hFFFF);
    send(CMD_FLUSH, 0, 0);
    set_capacity(17'd65536);

    // random phases with differing capacity
    for (int ph = 0; ph < 5; ph++) begin
      set_capacity(caps[ph]);
      if (ph == 4) no_stall = 1;
      for (int k = 0; k < 90; k++) begin
        case ($urandom_range(0, 9))
          0, 1, 2: send(CMD_ALLOC, rnd_count(), 16'($urandom));
          3, 4, 5, 6: send(CMD_MARK, 17'($urandom),
                           ($urandom_range(0, 4) == 0) ? 16'($urandom)
                                                        : 16'($urandom_range(0, 400)));
          7, 8: send(CMD_FLUSH, 17'($urandom), 16'($urandom));
          default: send(CMD_NONE, 17'($urandom), 16'($urandom));
        endcase
      end
      send(CMD_FLUSH, 0, 0);
    end
    drain();
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
`default_nettype wire

### bump_allocator_dirty_range_coalescer.f
src/badrc_pkg.sv
src/badrc_if.sv
src/badrc_ram.sv
src/badrc_fifo.sv
src/badrc_front.sv
src/badrc_back.sv
src/bump_allocator_dirty_range_coalescer.sv
test/badrc_checker.sv
test/bump_allocator_dirty_range_coalescer_tb.sv
